>>> rtl/m3inv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse unit.
package m3inv_pkg;

    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int EPS_W = 16;
    localparam int NUM_ELEM = 9;
    localparam int OP_INVERT = 0;
    localparam int OP_SET_FALLBACK = 1;
    localparam int IN_DATA_W = 288;
    localparam int OUT_DATA_W = 288;
    localparam int QUEUE_DEPTH = 2;

    // One queued job: the matrix with its operation code.
    typedef struct packed {
        logic                  op;
        logic [NUM_ELEM*32-1:0] mat;
    } m3inv_job_t;

endpackage

>>> rtl/matrix3_inverse_unit.sv
// Channel     | Beat fields (low bit up)                          | Handshake
// s_axis      | tuser: operation; tdata: in_r0c0 .. in_r2c2       | tvalid/tready
// m_axis      | tuser: singular; tdata: out_r0c0 .. out_r2c2      | tvalid/tready
// cfg         | cfg_data: det_epsilon                             | cfg_wr
// An invert beat holds the back end through cofactor, determinant and divide steps;
// its result becomes valid in the same cycle as the back end can take the next beat.
// Set-fallback beats are taken while idle; a two-entry queue lets the front run ahead.
// Reset clears control state, det_epsilon to 1 and the fallback matrix to zero.
// A stalled result stays in the output register; the back end only waits at its end.
module matrix3_inverse_unit
    import m3inv_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // in_r0c0 .. in_r2c2
    input  logic                  s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_r0c0 .. out_r2c2
    output logic                  m_axis_tuser,   // singular
    input  logic                  cfg_wr,
    input  logic [EPS_W-1:0]      cfg_data        // det_epsilon
);

    logic                 q_valid, q_ready, q_op;
    logic [IN_DATA_W-1:0] q_mat;
    logic [EPS_W-1:0]     eps_reg;

    // Epsilon register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_W'(1);
        else if (cfg_wr)
            eps_reg <= cfg_data;
    end

    m3inv_front #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser), .in_mat(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_mat(q_mat)
    );

    m3inv_back #(.ELEMENT_WIDTH(ELEMENT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_mat(q_mat),
        .eps(eps_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_mat(m_axis_tdata), .out_singular(m_axis_tuser)
    );

endmodule

>>> rtl/m3inv_front.sv
// Front end: accepts input beats, trims elements and queues every job in arrival order.
module m3inv_front
    import m3inv_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_op,
    input  logic [IN_DATA_W-1:0]  in_mat,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic                  q_op,
    output logic [IN_DATA_W-1:0]  q_mat
);

    m3inv_job_t           q_job_reg [QUEUE_DEPTH];
    logic [1:0]           q_count_reg, q_count_next;
    logic                 q_rd_reg, q_wr_reg;
    logic                 push, pop;
    logic [IN_DATA_W-1:0] ext_mat;

    // Keep only the low element bits, sign-extended to 32.
    always_comb
    begin
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            ext_mat[i*32 +: 32] = 32'(signed'(in_mat[i*32 +: ELEMENT_WIDTH]));
        end
    end

    // Both kinds of beat go through the queue so that fallback writes stay in order.
    assign in_ready = (q_count_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (q_count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_op     = q_job_reg[q_rd_reg].op;
    assign q_mat    = q_job_reg[q_rd_reg].mat;
    assign q_count_next = q_count_reg + 2'(push) - 2'(pop);

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg  <= '0;
            q_rd_reg     <= 1'b0;
            q_wr_reg     <= 1'b0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (push)
                q_wr_reg <= ~q_wr_reg;
            if (pop)
                q_rd_reg <= ~q_rd_reg;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_job_reg[q_wr_reg].op  <= in_op;
            q_job_reg[q_wr_reg].mat <= ext_mat;
        end
    end

endmodule

>>> rtl/m3inv_back.sv
// Back end: cofactors, determinant, shared serial divider and output register.
module m3inv_back
    import m3inv_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic                  q_op,
    input  logic [IN_DATA_W-1:0]  q_mat,
    input  logic [EPS_W-1:0]      eps,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_mat,
    output logic                  out_singular
);

    localparam int EW   = ELEMENT_WIDTH;
    localparam int CW   = 2*EW + 1;
    localparam int DW   = 3*EW + 2;
    localparam int NW   = CW + 2*FRACTION_BITS;
    localparam int QW   = NW;
    localparam int CNTW = $clog2(QW + 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COF  = 3'd1;
    localparam logic [2:0] ST_DET  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]                st_reg, st_next;
    logic signed [EW-1:0]      m_reg [NUM_ELEM];
    logic signed [CW-1:0]      cof_reg [NUM_ELEM];
    logic signed [DW-1:0]      det_reg;
    logic [DW-1:0]             dabs_reg;
    logic [3:0]                idx_reg;
    logic [CNTW-1:0]           bit_reg;
    logic [NW-1:0]             num_reg;
    logic [DW:0]               rem_reg;
    logic [QW-1:0]             quo_reg;
    logic                      neg_reg;
    logic [OUT_DATA_W-1:0]     res_reg;
    logic [OUT_DATA_W-1:0]     out_mat_reg;
    logic                      out_sing_reg;
    logic                      ov_reg;
    logic [IN_DATA_W-1:0]      fallback_reg;
    logic                      fb_write;
    logic                      out_load;
    logic                      near_zero;
    logic [DW:0]               rem_sh;
    logic signed [CW-1:0]      cur_cof;
    logic [CW-1:0]             cof_abs;
    logic [QW-1:0]             lim;
    logic [QW-1:0]             mag;
    logic [EW-1:0]             sval;
    logic signed [EW-1:0]      det_m;
    logic signed [CW-1:0]      det_c;
    logic signed [2*EW:0]      p_lo;
    logic signed [2*EW:0]      p_hi;
    logic signed [DW-1:0]      det_term;

    // Element (r,c) lives at index c*3+r.
    function automatic logic [3:0] ix(input int r, input int c);
        return 4'((c % 3) * 3 + (r % 3));
    endfunction

    // One cofactor: a*b - d*e, exact at cofactor width.
    function automatic logic signed [CW-1:0] cof_term(input logic signed [EW-1:0] a,
                                                      input logic signed [EW-1:0] b,
                                                      input logic signed [EW-1:0] d,
                                                      input logic signed [EW-1:0] e);
        logic signed [CW-1:0] p;
        logic signed [CW-1:0] q;
        p = a * b;
        q = d * e;
        return p - q;
    endfunction

    assign q_ready      = (st_reg == ST_IDLE);
    assign fb_write     = q_valid && q_ready && (q_op == 1'(OP_SET_FALLBACK));
    assign out_load     = (st_reg == ST_OUT) && (!ov_reg || out_ready);
    assign out_valid    = ov_reg;
    assign out_mat      = out_mat_reg;
    assign out_singular = out_sing_reg;
    assign near_zero    = (dabs_reg <= (DW'(eps) << (2*FRACTION_BITS)));

    // Output (r,c) sits in slot c*3+r and takes cofactor (c,r), stored at the same index.
    assign cur_cof = cof_reg[idx_reg];
    assign cof_abs = cur_cof[CW-1] ? CW'(-cur_cof) : CW'(cur_cof);
    assign rem_sh  = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign lim     = QW'((64'd1 << (EW-1)) - (neg_reg ? 64'd0 : 64'd1));
    assign mag     = (quo_reg > lim) ? lim : quo_reg;
    assign sval    = neg_reg ? EW'(-mag) : EW'(mag);

    // One determinant term per cycle, the cofactor split into a low and a high half.
    assign det_m    = m_reg[idx_reg];
    assign det_c    = cof_reg[idx_reg * 4'd3];
    assign p_lo     = det_m * $signed({1'b0, det_c[EW-1:0]});
    assign p_hi     = det_m * $signed(det_c[CW-1:EW]);
    assign det_term = DW'(p_lo) + (DW'(p_hi) << EW);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (q_valid && q_ready && q_op == 1'(OP_INVERT)) st_next = ST_COF;
            ST_COF:  st_next = ST_DET;
            ST_DET:  if (idx_reg == 4'd2) st_next = ST_DIV;
            ST_DIV:  if (bit_reg == CNTW'(1)) st_next = ST_SAT;
            ST_SAT:  st_next = (idx_reg == 4'd8) ? ST_OUT : ST_DIV;
            ST_OUT:  if (!ov_reg || out_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // Control state and the fallback matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            ov_reg       <= 1'b0;
            fallback_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (fb_write)
                fallback_reg <= q_mat;
        end
    end

    // Datapath: one cofactor stage, three determinant steps, a radix-2 divider.
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < NUM_ELEM; i++)
                    m_reg[i] <= EW'(q_mat[i*32 +: 32]);
            end
            ST_COF:
            begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        cof_reg[r*3+c] <= cof_term(m_reg[ix(r+1,c+1)], m_reg[ix(r+2,c+2)],
                                                   m_reg[ix(r+1,c+2)], m_reg[ix(r+2,c+1)]);
                det_reg <= '0;
                idx_reg <= 4'd0;
            end
            ST_DET:
            begin
                det_reg <= det_reg + det_term;
                if (idx_reg == 4'd2)
                begin
                    idx_reg <= 4'd0;
                    bit_reg <= CNTW'(QW + 1);
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                else
                    idx_reg <= idx_reg + 4'd1;
            end
            ST_DIV:
            begin
                if (bit_reg == CNTW'(QW + 1))
                begin
                    dabs_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
                    num_reg  <= NW'(cof_abs) << (2*FRACTION_BITS);
                    neg_reg  <= cur_cof[CW-1] ^ det_reg[DW-1];
                    bit_reg  <= CNTW'(QW);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                end
                else
                begin
                    if (rem_sh >= {1'b0, dabs_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, dabs_reg};
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    bit_reg <= bit_reg - CNTW'(1);
                end
            end
            ST_SAT:
            begin
                res_reg[idx_reg*32 +: 32] <= 32'(signed'(sval));
                idx_reg <= idx_reg + 4'd1;
                bit_reg <= CNTW'(QW + 1);
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_mat_reg  <= near_zero ? fallback_reg : res_reg;
                    out_sing_reg <= near_zero;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/m3inv_checker.sv
// Port-level checker for the matrix inverse unit, with its bind.
module m3inv_checker
    import m3inv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // A stalled result beat keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A stalled flag keeps its value.
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
        else $error("singular changed while stalled");

    // A valid result beat carries fully known data and flag.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
        else $error("result beat carries unknown bits");

endmodule

bind matrix3_inverse_unit m3inv_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

>>> dv/testbench.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
module testbench;
    import m3inv_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [OUT_DATA_W-1:0] mat;
        logic                  singular;
    } inverse_t;

    typedef struct {
        logic                 op;
        logic [IN_DATA_W-1:0] mat;
        logic                 typed;
        logic [IN_DATA_W-1:0] want_mat;
        logic                 want_singular;
    } stim_row_t;

    localparam logic [31:0] ONE      = 32'h0001_0000;
    localparam logic [31:0] HALF     = 32'h0000_8000;
    localparam logic [31:0] MAX_ELEM = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_ELEM = 32'h8000_0000;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL   = 100;
    localparam int HOLD_CYCLES  = 6000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_wr;
    logic [EPS_W-1:0]      cfg_data;

    // Predictor state mirrored from the block.
    logic [EPS_W-1:0]      model_epsilon;
    logic [IN_DATA_W-1:0]  model_fallback;
    inverse_t              expected_inverses[$];
    int                    mismatches;
    int                    beats_sent;
    bit                    quiet;
    bit                    hold_request;

    matrix3_inverse_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr        (cfg_wr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Build a diagonal matrix; element (r,c) sits in slot c*3+r.
    function automatic logic [IN_DATA_W-1:0] diag_matrix(logic [31:0] a, logic [31:0] b,
                                                         logic [31:0] c);
        logic [IN_DATA_W-1:0] m;
        m = '0;
        m[0 +: 32]   = a;
        m[128 +: 32] = b;
        m[256 +: 32] = c;
        return m;
    endfunction

    // Exact adjugate inverse, truncated toward zero and saturated; fallback when near zero.
    function automatic inverse_t predict_inverse(logic [IN_DATA_W-1:0] d);
        wide_t          m[3][3];
        wide_t          cof[3][3];
        wide_t          det;
        logic [127:0]   det_mag;
        logic [127:0]   num_mag;
        logic [127:0]   quot;
        logic [127:0]   limit;
        logic [127:0]   mag;
        logic [127:0]   threshold;
        logic           neg;
        inverse_t       res;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                m[r][c] = wide_t'(signed'(d[(c*3+r)*32 +: 32]));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                cof[r][c] = m[(r+1)%3][(c+1)%3] * m[(r+2)%3][(c+2)%3]
                          - m[(r+1)%3][(c+2)%3] * m[(r+2)%3][(c+1)%3];
        det = m[0][0]*cof[0][0] + m[1][0]*cof[1][0] + m[2][0]*cof[2][0];
        det_mag = (det < 0) ? -det : det;
        threshold = {96'd0, 16'd0, model_epsilon} << 32;
        if (det_mag <= threshold)
        begin
            res.mat = model_fallback;
            res.singular = 1'b1;
            return res;
        end
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
            begin
                neg = (cof[c][r] < 0) != (det < 0);
                num_mag = (cof[c][r] < 0) ? -cof[c][r] : cof[c][r];
                quot = (num_mag << 32) / det_mag;
                limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                mag = (quot > limit) ? limit : quot;
                res.mat[(c*3+r)*32 +: 32] = neg ? 32'(-mag) : mag[31:0];
            end
        res.singular = 1'b0;
        return res;
    endfunction

    // Offer one beat, wait for it to be taken, then record what it should produce.
    task automatic send_beat(stim_row_t row);
        inverse_t want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.mat;
        s_axis_tuser  <= row.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        if (row.op == 1'(OP_SET_FALLBACK))
            model_fallback = row.mat;
        else if (row.typed)
        begin
            want.mat = row.want_mat;
            want.singular = row.want_singular;
            expected_inverses.push_back(want);
        end
        else
            expected_inverses.push_back(predict_inverse(row.mat));
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Write the threshold once every result is home and the queue has drained.
    task automatic write_epsilon(logic [EPS_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_inverses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_wr   <= 1'b1;
        cfg_data <= value;
        model_epsilon = value;
        @(posedge clk);
        cfg_wr <= 1'b0;
    endtask

    // Random matrices: raw bits, small values, nearly dependent rows, scaled diagonals.
    function automatic logic [IN_DATA_W-1:0] random_matrix();
        logic [IN_DATA_W-1:0] m;
        int                   kind;
        int                   v[3][3];
        kind = $urandom_range(0, 9);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                v[r][c] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        if (kind < 4)
        begin
            for (int i = 0; i < NUM_ELEM; i++)
                v[i%3][i/3] = int'($urandom);
        end
        else if (kind < 8)
        begin
            for (int c = 0; c < 3; c++)
                v[2][c] = v[0][c] + v[1][c] + int'($urandom_range(0, 3)) - 1;
        end
        else if (kind < 9)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    v[r][c] = (r == c) ? int'($urandom_range(1, 1 << 20))
                                       : int'($urandom_range(0, 15)) - 8;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[(c*3+r)*32 +: 32] = v[r][c];
        return m;
    endfunction

    task automatic run_random(int count);
        stim_row_t row;
        for (int i = 0; i < count; i++)
        begin
            row.op = ($urandom_range(0, 9) == 0) ? 1'(OP_SET_FALLBACK) : 1'(OP_INVERT);
            row.mat = random_matrix();
            row.typed = 1'b0;
            row.want_mat = '0;
            row.want_singular = 1'b0;
            if (beats_sent >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send_beat(row);
        end
    endtask

    // Stimulus: directed table, then random phases at several thresholds.
    initial
    begin
        stim_row_t table_rows[$];
        logic [IN_DATA_W-1:0] fb;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_wr = 1'b0;
        cfg_data = '0;
        model_epsilon = 16'd1;
        model_fallback = '0;
        mismatches = 0;
        beats_sent = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        fb = diag_matrix(32'h0003_0000, 32'hFFFF_0000, 32'h1234_5678);
        fb[32 +: 32] = 32'hDEAD_BEEF;
        table_rows = '{
            // Zero matrix straight after reset returns the cleared fallback.
            '{1'(OP_INVERT), '0, 1'b1, '0, 1'b1},
            '{1'(OP_INVERT), diag_matrix(ONE, ONE, ONE), 1'b1,
              diag_matrix(ONE, ONE, ONE), 1'b0},
            '{1'(OP_SET_FALLBACK), fb, 1'b0, '0, 1'b0},
            '{1'(OP_INVERT), '0, 1'b1, fb, 1'b1},
            '{1'(OP_INVERT), diag_matrix(2*ONE, 2*ONE, 2*ONE), 1'b1,
              diag_matrix(HALF, HALF, HALF), 1'b0},
            // Tiny determinant counts as near zero.
            '{1'(OP_INVERT), diag_matrix(32'd1, 32'd1, 32'd1), 1'b1, fb, 1'b1},
            // Determinant exactly at the threshold is still near zero.
            '{1'(OP_INVERT), diag_matrix(32'd1, ONE, ONE), 1'b1, fb, 1'b1},
            // Just above the threshold: the quotient saturates high.
            '{1'(OP_INVERT), diag_matrix(32'd2, ONE, ONE), 1'b1,
              diag_matrix(MAX_ELEM, ONE, ONE), 1'b0},
            // Negative side reaches the smallest element without saturating.
            '{1'(OP_INVERT), diag_matrix(32'hFFFF_FFFE, ONE, ONE), 1'b1,
              diag_matrix(MIN_ELEM, ONE, ONE), 1'b0},
            '{1'(OP_INVERT), {NUM_ELEM{MAX_ELEM}}, 1'b1, fb, 1'b1},
            '{1'(OP_INVERT), {NUM_ELEM{MIN_ELEM}}, 1'b1, fb, 1'b1},
            '{1'(OP_INVERT), diag_matrix(MAX_ELEM, MIN_ELEM, MAX_ELEM), 1'b0, '0, 1'b0},
            '{1'(OP_INVERT), diag_matrix(MIN_ELEM, MIN_ELEM, MIN_ELEM), 1'b0, '0, 1'b0},
            '{1'(OP_INVERT), {ONE, MIN_ELEM, MAX_ELEM, 32'hFFFF_8000, 32'h0002_0000,
                              32'h0000_0001, MAX_ELEM, ONE, 32'hFFFE_0000}, 1'b0, '0, 1'b0},
            '{1'(OP_SET_FALLBACK), {NUM_ELEM{MIN_ELEM}}, 1'b0, '0, 1'b0},
            '{1'(OP_INVERT), '0, 1'b1, {NUM_ELEM{MIN_ELEM}}, 1'b1},
            '{1'(OP_SET_FALLBACK), {NUM_ELEM{MAX_ELEM}}, 1'b0, '0, 1'b0},
            '{1'(OP_INVERT), {NUM_ELEM{32'h0001_0000}}, 1'b1, {NUM_ELEM{MAX_ELEM}}, 1'b1}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
            send_beat(table_rows[i]);

        beats_sent = 0;
        write_epsilon(16'd0);
        // Receiver holds off for a long stretch while beats keep coming.
        hold_request = 1'b1;
        run_random(100);
        write_epsilon(16'hFFFF);
        run_random(100);
        write_epsilon(16'($urandom_range(2, 16'hFFFE)));
        run_random(100);
        write_epsilon(16'd1);
        run_random(200);
        s_axis_tvalid <= 1'b0;

        while (expected_inverses.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random short stalls, one long hold, none near the end.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && rst_n && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= rst_n;
        end
    end

    // Compare each result beat with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        inverse_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_inverses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: data %h singular %b",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_inverses.pop_front();
                for (int i = 0; i < NUM_ELEM; i++)
                    if (m_axis_tdata[i*32 +: 32] !== want.mat[i*32 +: 32])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Element r%0dc%0d: expected %h, got %h", i % 3, i / 3,
                                     want.mat[i*32 +: 32], m_axis_tdata[i*32 +: 32]);
                    end
                if (m_axis_tuser !== want.singular)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Singular flag: expected %b, got %b",
                                 want.singular, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> matrix3_inverse_unit.f
rtl/m3inv_pkg.sv
rtl/m3inv_front.sv
rtl/m3inv_back.sv
rtl/matrix3_inverse_unit.sv
rtl/m3inv_checker.sv
dv/testbench.sv
